FILE: hw/rtl/mfda_pkg.sv
// Shared types, codes and constants for the masked frame difference alarm.
`default_nettype none
package mfda_pkg;

    // Default frame geometry
    localparam int FRAME_WIDTH_DEF  = 160;
    localparam int FRAME_HEIGHT_DEF = 120;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int PIXEL_W  = 8;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int SUM_W    = 23;
    localparam int COUNT_W  = 15;
    localparam int HOLD_W   = 16;
    localparam int THR_W    = 9;
    localparam int PROD_W   = THR_W + COUNT_W;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Input item kinds
    localparam logic [ACTION_W-1:0] ACT_COMPARE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_HOLD = 3'd7;

    // Register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 9'd12;
    localparam logic [COL_W-1:0]  ROI_WIDTH_RST  = 8'd160;
    localparam logic [ROW_W-1:0]  ROI_HEIGHT_RST = 7'd120;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 16'd1000;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_halves;
        logic              roi_enable;
        logic [COL_W-1:0]  roi_left;
        logic [ROW_W-1:0]  roi_top;
        logic [COL_W-1:0]  roi_width;
        logic [ROW_W-1:0]  roi_height;
        logic [HOLD_W-1:0] alarm_hold_ticks;
        logic [HOLD_W-1:0] clear_hold_ticks;
    } mfda_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic                hit;
        logic                frame_end;
    } mfda_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mfda_front.sv
// Input stage: frame and ROI check, background address computation.
`default_nettype none
module mfda_front #(
    parameter int FRAME_WIDTH  = mfda_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mfda_pkg::FRAME_HEIGHT_DEF,
    parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                en,
    input  wire                                in_valid,
    input  wire [mfda_pkg::ACTION_W-1:0]       action,
    input  wire [mfda_pkg::PIXEL_W-1:0]        pixel,
    input  wire [mfda_pkg::COL_W-1:0]          col,
    input  wire [mfda_pkg::ROW_W-1:0]          row,
    input  wire                                frame_end,
    input  mfda_pkg::mfda_cfg_t                cfg,
    output mfda_pkg::mfda_ctl_t                ctl_reg,
    output logic [mfda_pkg::PIXEL_W-1:0]       pixel_reg,
    output logic [AW-1:0]                      addr_reg
);

    logic [mfda_pkg::COL_W:0] col_end;
    logic [mfda_pkg::ROW_W:0] row_end;
    logic                     in_frame;
    logic                     in_roi;
    logic                     hit;
    logic [31:0]              addr_full;
    mfda_pkg::mfda_ctl_t      ctl_next;

    always_comb
    begin
        col_end   = {1'b0, cfg.roi_left} + {1'b0, cfg.roi_width};
        row_end   = {1'b0, cfg.roi_top} + {1'b0, cfg.roi_height};
        in_frame  = (32'(col) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));
        in_roi    = !cfg.roi_enable ||
                    ((col >= cfg.roi_left) && ({1'b0, col} < col_end) &&
                     (row >= cfg.roi_top) && ({1'b0, row} < row_end));
        // loads ignore the ROI, only the frame bounds apply
        hit       = in_frame && ((action == mfda_pkg::ACT_LOAD) || in_roi);
        addr_full = 32'(row) * 32'(FRAME_WIDTH) + 32'(col);
        ctl_next.valid     = in_valid;
        ctl_next.action    = action;
        ctl_next.hit       = hit;
        ctl_next.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel;
            addr_reg  <= addr_full[AW-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mfda_bg_store.sv
// Background frame memory: load writes, registered compare reads.
`default_nettype none
module mfda_bg_store #(
    parameter int DEPTH = mfda_pkg::FRAME_WIDTH_DEF * mfda_pkg::FRAME_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                en,
    input  mfda_pkg::mfda_ctl_t                ctl_in,
    input  wire [mfda_pkg::PIXEL_W-1:0]        pixel_in,
    input  wire [AW-1:0]                       addr_in,
    output mfda_pkg::mfda_ctl_t                ctl_reg,
    output logic [mfda_pkg::PIXEL_W-1:0]       pixel_reg,
    output logic [mfda_pkg::PIXEL_W-1:0]       bg_reg
);

    logic [mfda_pkg::PIXEL_W-1:0] mem [0:DEPTH-1];
    logic                         wr_en;

    assign wr_en = en && ctl_in.valid && ctl_in.hit && (ctl_in.action == mfda_pkg::ACT_LOAD);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_in] <= pixel_in;
        end
    end

    // loads and compares pass in order, so a load is in memory before any later read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bg_reg    <= mem[addr_in];
            pixel_reg <= pixel_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mfda_accum.sv
// Frame accumulator: saturating sum of absolute differences and pixel count.
`default_nettype none
module mfda_accum (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                en,
    input  mfda_pkg::mfda_ctl_t                ctl_in,
    input  wire [mfda_pkg::PIXEL_W-1:0]        pixel_in,
    input  wire [mfda_pkg::PIXEL_W-1:0]        bg_in,
    output mfda_pkg::mfda_ctl_t                ctl_reg,
    output logic [mfda_pkg::SUM_W-1:0]         frame_sum_reg,
    output logic [mfda_pkg::COUNT_W-1:0]       frame_count_reg
);

    logic [mfda_pkg::SUM_W-1:0]   running_sum_reg;
    logic [mfda_pkg::SUM_W-1:0]   running_sum_next;
    logic [mfda_pkg::COUNT_W-1:0] running_count_reg;
    logic [mfda_pkg::COUNT_W-1:0] running_count_next;
    logic [mfda_pkg::PIXEL_W-1:0] diff;
    logic [mfda_pkg::SUM_W:0]     sum_ext;
    logic [mfda_pkg::SUM_W-1:0]   sum_upd;
    logic [mfda_pkg::COUNT_W-1:0] count_upd;
    logic                         is_compare;
    logic                         counted;

    always_comb
    begin
        is_compare = ctl_in.valid && (ctl_in.action == mfda_pkg::ACT_COMPARE);
        counted    = is_compare && ctl_in.hit;
        diff       = (pixel_in >= bg_in) ? (pixel_in - bg_in) : (bg_in - pixel_in);
        sum_ext    = {1'b0, running_sum_reg} + (mfda_pkg::SUM_W + 1)'(diff);
        sum_upd    = running_sum_reg;
        count_upd  = running_count_reg;
        if (counted)
        begin
            sum_upd   = sum_ext[mfda_pkg::SUM_W] ? '1 : sum_ext[mfda_pkg::SUM_W-1:0];
            count_upd = (&running_count_reg) ? running_count_reg
                                             : running_count_reg + 1'b1;
        end
        // drop the running totals once the frame closes
        if (is_compare && ctl_in.frame_end)
        begin
            running_sum_next   = '0;
            running_count_next = '0;
        end
        else
        begin
            running_sum_next   = sum_upd;
            running_count_next = count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= '0;
            running_count_reg <= '0;
            ctl_reg           <= '0;
        end
        else if (en)
        begin
            running_sum_reg   <= running_sum_next;
            running_count_reg <= running_count_next;
            ctl_reg           <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frame_sum_reg   <= sum_upd;
            frame_count_reg <= count_upd;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mfda_decide.sv
// Frame decision, debounced alarm, hold counter and result register.
`default_nettype none
module mfda_decide (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   en,
    input  mfda_pkg::mfda_ctl_t                   ctl_in,
    input  wire [mfda_pkg::SUM_W-1:0]             sum_in,
    input  wire [mfda_pkg::COUNT_W-1:0]           count_in,
    input  mfda_pkg::mfda_cfg_t                   cfg,
    input  wire                                   out_ready,
    output logic                                  stall,
    output logic                                  out_valid_reg,
    output logic [mfda_pkg::OUT_DATA_W-1:0]       out_data_reg
);

    localparam int PAD_W = mfda_pkg::OUT_DATA_W - 3 - mfda_pkg::SUM_W - mfda_pkg::COUNT_W;

    mfda_pkg::mfda_ctl_t           ctl_reg;
    logic [mfda_pkg::SUM_W-1:0]    sum_reg;
    logic [mfda_pkg::COUNT_W-1:0]  count_reg;
    logic [mfda_pkg::PROD_W-1:0]   prod_reg;
    logic [mfda_pkg::PROD_W-1:0]   prod_next;
    logic [mfda_pkg::COUNT_W-1:0]  denom;
    logic                          alarm_reg;
    logic                          alarm_next;
    logic [mfda_pkg::HOLD_W-1:0]   hold_reg;
    logic [mfda_pkg::HOLD_W-1:0]   hold_next;
    logic                          result;
    logic                          is_tick;
    logic                          detected;
    logic                          raised;
    logic [mfda_pkg::PROD_W-1:0]   sum2;

    always_comb
    begin
        denom     = (count_in == '0) ? mfda_pkg::COUNT_W'(1) : count_in;
        prod_next = mfda_pkg::PROD_W'(cfg.threshold_halves) * mfda_pkg::PROD_W'(denom);
    end

    always_comb
    begin
        result   = ctl_reg.valid && (ctl_reg.action == mfda_pkg::ACT_COMPARE) &&
                   ctl_reg.frame_end;
        is_tick  = ctl_reg.valid && (ctl_reg.action == mfda_pkg::ACT_TICK);
        stall    = result && out_valid_reg && !out_ready;
        sum2     = {sum_reg, 1'b0};
        detected = (sum2 >= prod_reg);
        raised     = 1'b0;
        alarm_next = alarm_reg;
        hold_next  = hold_reg;
        if (is_tick)
        begin
            hold_next = (&hold_reg) ? hold_reg : hold_reg + 1'b1;
        end
        else if (result)
        begin
            if (!alarm_reg)
            begin
                if (detected && (hold_reg >= cfg.clear_hold_ticks))
                begin
                    alarm_next = 1'b1;
                    hold_next  = '0;
                    raised     = 1'b1;
                end
            end
            else if (!detected && (hold_reg >= cfg.alarm_hold_ticks))
            begin
                alarm_next = 1'b0;
                hold_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            alarm_reg     <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                ctl_reg   <= ctl_in;
                alarm_reg <= alarm_next;
                hold_reg  <= hold_next;
            end
            if (en && result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_in;
            count_reg <= count_in;
            prod_reg  <= prod_next;
        end
        if (en && result)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, count_reg, sum_reg, raised, detected, alarm_next};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/masked_frame_diff_alarm.sv
// Top level: configuration registers and the five-stage pixel pipeline.
//
//  channel   direction  payload
//  s_axis    in         tuser action; tdata pixel, col, row; tlast frame_end
//  m_axis    out        tdata alarm, detected, alarm_raised, diff_sum, pixel_count
//  cfg       in         cfg_we, cfg_addr register index, cfg_wdata value
//
// One transaction per cycle enters while the pipeline is not held; m_axis_tvalid
// for a frame result rises once its closing pixel has passed the address stage,
// the background memory read, the accumulator, the threshold multiplier and the
// decision.
// Reset clears the totals, alarm, hold counter and registers; the background
// memory is not cleared. The whole pipeline holds only while a frame result
// waits at the decision stage and the output register is still occupied.
`default_nettype none
module masked_frame_diff_alarm #(
    parameter int FRAME_WIDTH  = mfda_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mfda_pkg::FRAME_HEIGHT_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel [7:0], col [15:8], row [22:16], zero [23]
    input  wire [mfda_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // action [1:0]
    input  wire [mfda_pkg::ACTION_W-1:0]          s_axis_tuser,
    input  wire                                   s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // alarm [0], detected [1], alarm_raised [2], diff_sum [25:3],
    // pixel_count [40:26], zero [47:41]
    output logic [mfda_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire                                   cfg_we,
    input  wire [mfda_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  wire [mfda_pkg::CFG_W-1:0]             cfg_wdata
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    mfda_pkg::mfda_cfg_t             cfg_reg;
    mfda_pkg::mfda_ctl_t             ctl_front;
    mfda_pkg::mfda_ctl_t             ctl_store;
    mfda_pkg::mfda_ctl_t             ctl_accum;
    logic [mfda_pkg::PIXEL_W-1:0]    pixel_front;
    logic [mfda_pkg::PIXEL_W-1:0]    pixel_store;
    logic [mfda_pkg::PIXEL_W-1:0]    bg_store;
    logic [AW-1:0]                   addr_front;
    logic [mfda_pkg::SUM_W-1:0]      frame_sum;
    logic [mfda_pkg::COUNT_W-1:0]    frame_count;
    logic                            stall;
    logic                            en;

    assign en            = !stall;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_halves <= mfda_pkg::THRESHOLD_RST;
            cfg_reg.roi_enable       <= 1'b0;
            cfg_reg.roi_left         <= '0;
            cfg_reg.roi_top          <= '0;
            cfg_reg.roi_width        <= mfda_pkg::ROI_WIDTH_RST;
            cfg_reg.roi_height       <= mfda_pkg::ROI_HEIGHT_RST;
            cfg_reg.alarm_hold_ticks <= mfda_pkg::HOLD_TICKS_RST;
            cfg_reg.clear_hold_ticks <= mfda_pkg::HOLD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mfda_pkg::REG_THRESHOLD:
                    cfg_reg.threshold_halves <= cfg_wdata[mfda_pkg::THR_W-1:0];
                mfda_pkg::REG_ROI_ENABLE:
                    cfg_reg.roi_enable <= cfg_wdata[0];
                mfda_pkg::REG_ROI_LEFT:
                    cfg_reg.roi_left <= cfg_wdata[mfda_pkg::COL_W-1:0];
                mfda_pkg::REG_ROI_TOP:
                    cfg_reg.roi_top <= cfg_wdata[mfda_pkg::ROW_W-1:0];
                mfda_pkg::REG_ROI_WIDTH:
                    cfg_reg.roi_width <= cfg_wdata[mfda_pkg::COL_W-1:0];
                mfda_pkg::REG_ROI_HEIGHT:
                    cfg_reg.roi_height <= cfg_wdata[mfda_pkg::ROW_W-1:0];
                mfda_pkg::REG_ALARM_HOLD:
                    cfg_reg.alarm_hold_ticks <= cfg_wdata;
                mfda_pkg::REG_CLEAR_HOLD:
                    cfg_reg.clear_hold_ticks <= cfg_wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    mfda_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .action    (s_axis_tuser),
        .pixel     (s_axis_tdata[7:0]),
        .col       (s_axis_tdata[15:8]),
        .row       (s_axis_tdata[22:16]),
        .frame_end (s_axis_tlast),
        .cfg       (cfg_reg),
        .ctl_reg   (ctl_front),
        .pixel_reg (pixel_front),
        .addr_reg  (addr_front)
    );

    mfda_bg_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bg_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_front),
        .pixel_in  (pixel_front),
        .addr_in   (addr_front),
        .ctl_reg   (ctl_store),
        .pixel_reg (pixel_store),
        .bg_reg    (bg_store)
    );

    mfda_accum u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .ctl_in          (ctl_store),
        .pixel_in        (pixel_store),
        .bg_in           (bg_store),
        .ctl_reg         (ctl_accum),
        .frame_sum_reg   (frame_sum),
        .frame_count_reg (frame_count)
    );

    mfda_decide u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .ctl_in        (ctl_accum),
        .sum_in        (frame_sum),
        .count_in      (frame_count),
        .cfg           (cfg_reg),
        .out_ready     (m_axis_tready),
        .stall         (stall),
        .out_valid_reg (m_axis_tvalid),
        .out_data_reg  (m_axis_tdata)
    );

endmodule
`default_nettype wire
